// ----- rtl/cftss_pkg.sv -----
`timescale 1ns / 1ps

package cftss_pkg;

	localparam int unsigned OUT_W    = 12;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned COORD_W  = 10;
	localparam int unsigned CREDIT_W = 17;

	localparam logic [CREDIT_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_UPDATE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic read;
		logic update;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic search_end;
	} status_t;

endpackage

// ----- rtl/conflict_free_task_subset_select.sv -----
`timescale 1ns / 1ps
// Task requests load at one per cycle; the request marked last ends the set.
// The subset search then visits each nonempty subset in turn, a read state
// and an update state for each; the result is offered after the last one, and
// new requests stall until it is taken.
// Subset totals sit in a 2^MAX_TASKS entry memory with one access per cycle.
// Reset clears the controller and the task count; no memory clearing pass.
module conflict_free_task_subset_select
	import cftss_pkg::*;
#(
	parameter int unsigned MAX_TASKS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                task_valid,
	output logic                task_stall,
	input  logic [TIME_W-1:0]   start_time,
	input  logic [TIME_W-1:0]   duration,
	input  logic [COORD_W-1:0]  pos_x,
	input  logic [COORD_W-1:0]  pos_y,
	input  logic [COORD_W-1:0]  width,
	input  logic [COORD_W-1:0]  height,
	input  logic                placed,
	input  logic [CREDIT_W-1:0] credit,
	input  logic                last,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [OUT_W-1:0]    chosen_mask
);

	cmd_t    cmd;
	status_t status;

	cftss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.task_valid   (task_valid),
		.last         (last),
		.task_stall   (task_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	cftss_dp #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.start_time  (start_time),
		.duration    (duration),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.width       (width),
		.height      (height),
		.placed      (placed),
		.credit      (credit),
		.chosen_mask (chosen_mask)
	);

endmodule

// ----- rtl/cftss_ctrl.sv -----
`timescale 1ns / 1ps

module cftss_ctrl
	import cftss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    task_valid,
	input  logic    last,
	output logic    task_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next   = state_q;
		cmd          = '0;
		task_stall   = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			ST_LOAD: begin
				task_stall = 1'b0;
				if (task_valid) begin
					cmd.load = 1'b1;
					if (last) begin
						cmd.start  = 1'b1;
						state_next = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.read   = 1'b1;
				state_next = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				if (status.search_end) begin
					state_next = ST_DONE;
				end else begin
					state_next = ST_READ;
				end
			end
			ST_DONE: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					cmd.clear  = 1'b1;
					state_next = ST_LOAD;
				end
			end
			default: begin
				state_next = ST_LOAD;
			end
		endcase
	end

endmodule

// ----- rtl/cftss_dp.sv -----
`timescale 1ns / 1ps

module cftss_dp
	import cftss_pkg::*;
#(
	parameter int unsigned MAX_TASKS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output status_t             status,
	input  logic [TIME_W-1:0]   start_time,
	input  logic [TIME_W-1:0]   duration,
	input  logic [COORD_W-1:0]  pos_x,
	input  logic [COORD_W-1:0]  pos_y,
	input  logic [COORD_W-1:0]  width,
	input  logic [COORD_W-1:0]  height,
	input  logic                placed,
	input  logic [CREDIT_W-1:0] credit,
	output logic [OUT_W-1:0]    chosen_mask
);

	localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
	localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned SUM_W = $clog2(MAX_TASKS * 65536 + 1);
	localparam int unsigned ENT_W = SUM_W + 1;
	localparam int unsigned DEPTH = 2 ** MAX_TASKS;

	logic [TIME_W-1:0]    st_q   [MAX_TASKS];
	logic [TIME_W-1:0]    du_q   [MAX_TASKS];
	logic [COORD_W-1:0]   x_q    [MAX_TASKS];
	logic [COORD_W-1:0]   y_q    [MAX_TASKS];
	logic [COORD_W-1:0]   w_q    [MAX_TASKS];
	logic [COORD_W-1:0]   h_q    [MAX_TASKS];
	logic                 plc_q  [MAX_TASKS];
	logic [CREDIT_W-1:0]  wgt_q  [MAX_TASKS];
	logic [MAX_TASKS-1:0] crow_q [MAX_TASKS];

	logic [ENT_W-1:0]     mem_q  [DEPTH];

	logic [CNT_W-1:0]     count_q;
	logic [MAX_TASKS-1:0] m_q;
	logic [MAX_TASKS-1:0] lim_q;
	logic [MAX_TASKS-1:0] rest_q;
	logic [IDX_W-1:0]     low_q;
	logic [ENT_W-1:0]     rd_q;
	logic [SUM_W-1:0]     best_q;
	logic [MAX_TASKS-1:0] bmask_q;

	logic                 has_room;
	logic [IDX_W-1:0]     wr_idx;
	logic [CNT_W-1:0]     n_next;
	logic [MAX_TASKS-1:0] lim_next;
	logic [MAX_TASKS-1:0] hit;
	logic [CREDIT_W-1:0]  wgt_new;
	logic [MAX_TASKS-1:0] rest_next;
	logic [IDX_W-1:0]     low_next;
	logic                 reach;
	logic [SUM_W-1:0]     base_sum;
	logic [SUM_W-1:0]     new_sum;
	logic                 ok;
	logic [MAX_TASKS+OUT_W-1:0] mask_pad;

	assign has_room = count_q < CNT_W'(MAX_TASKS);
	assign wr_idx   = count_q[IDX_W-1:0];
	assign n_next   = has_room ? count_q + CNT_W'(1) : count_q;
	assign wgt_new  = (credit > ONE_Q16) ? '0 : ONE_Q16 - credit;

	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			lim_next[i] = CNT_W'(i) < n_next;
		end
	end

	// A new request is checked against every stored task as it arrives.
	always_comb begin
		for (int j = 0; j < MAX_TASKS; j++) begin
			hit[j] = (CNT_W'(j) < count_q) && plc_q[j] && placed
				&& ((33'(st_q[j]) + 33'(du_q[j])) > 33'(start_time))
				&& ((33'(start_time) + 33'(duration)) > 33'(st_q[j]))
				&& (11'(x_q[j]) < 11'(pos_x) + 11'(width))
				&& (11'(pos_x) < 11'(x_q[j]) + 11'(w_q[j]))
				&& (11'(y_q[j]) < 11'(pos_y) + 11'(height))
				&& (11'(pos_y) < 11'(y_q[j]) + 11'(h_q[j]));
		end
	end

	always_comb begin
		low_next = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--) begin
			if (m_q[i]) begin
				low_next = IDX_W'(i);
			end
		end
	end

	assign rest_next = m_q & (m_q - MAX_TASKS'(1));

	assign reach    = (rest_q == '0) || rd_q[ENT_W-1];
	assign base_sum = (rest_q == '0) ? '0 : rd_q[SUM_W-1:0];
	assign new_sum  = base_sum + SUM_W'(wgt_q[low_q]);
	assign ok       = reach && plc_q[low_q] && ((rest_q & crow_q[low_q]) == '0);

	assign status.search_end = (m_q == lim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			m_q     <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.load && has_room) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start) begin
				m_q <= MAX_TASKS'(1);
			end else if (cmd.update) begin
				m_q <= m_q + MAX_TASKS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && has_room) begin
			st_q[wr_idx]   <= start_time;
			du_q[wr_idx]   <= duration;
			x_q[wr_idx]    <= pos_x;
			y_q[wr_idx]    <= pos_y;
			w_q[wr_idx]    <= width;
			h_q[wr_idx]    <= height;
			plc_q[wr_idx]  <= placed;
			wgt_q[wr_idx]  <= wgt_new;
			for (int j = 0; j < MAX_TASKS; j++) begin
				if (hit[j]) begin
					crow_q[j][wr_idx] <= 1'b1;
				end
			end
			crow_q[wr_idx] <= hit;
		end
		if (cmd.start) begin
			lim_q   <= lim_next;
			best_q  <= '0;
			bmask_q <= '0;
		end
		if (cmd.read) begin
			rest_q <= rest_next;
			low_q  <= low_next;
		end
		if (cmd.update && ok && (new_sum > best_q)) begin
			best_q  <= new_sum;
			bmask_q <= m_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			rd_q <= mem_q[rest_next];
		end
		if (cmd.update) begin
			mem_q[m_q] <= {ok, new_sum};
		end
	end

	assign mask_pad    = {{OUT_W{1'b0}}, bmask_q};
	assign chosen_mask = mask_pad[OUT_W-1:0];

endmodule
